// ===== hw/rtl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the Modbus RTU response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 9;
   localparam int STATUS_W  = 3;
   localparam int PAY_BYTES = 8;
   localparam int PAY_W     = PAY_BYTES * BYTE_W;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  EXC_BASE = 8'h80;

   localparam logic [LEN_W-1:0] MIN_FRAME = 9'd4;
   localparam logic [LEN_W:0]   HDR_CRC_BYTES = 10'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXCEPTION = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   slave_address;
      logic [BYTE_W-1:0]   function_code;
      logic [BYTE_W-1:0]   count_or_exception;
      logic [PAY_W-1:0]    payload_word;
      logic [LEN_W-1:0]    frame_length;
   } result_type;

endpackage

// ===== hw/rtl/mrc_crc_byte.sv =====
// ----------------------------------------------------------------------------
// mrc_crc_byte
// One byte of CRC-16 update, reflected polynomial, eight steps unrolled.
// ----------------------------------------------------------------------------
module mrc_crc_byte (
   input  logic [15:0]                 crc_cur,
   input  logic [mrc_pkg::BYTE_W-1:0]  data,
   output logic [15:0]                 crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mrc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end

endmodule

// ===== hw/rtl/mrc_frame.sv =====
// ----------------------------------------------------------------------------
// mrc_frame
// Per-frame state: delayed crc, byte count, header capture, status decision.
// ----------------------------------------------------------------------------
module mrc_frame #(
   parameter int MAX_PAYLOAD = 8,
   parameter int MAX_FRAME   = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [mrc_pkg::BYTE_W-1:0]  rx_byte,
   input  logic                        end_of_frame,
   output mrc_pkg::result_type         result
);

   localparam logic [mrc_pkg::LEN_W-1:0]  MAX_FRAME_C   = mrc_pkg::LEN_W'(MAX_FRAME);
   localparam logic [mrc_pkg::BYTE_W-1:0] MAX_PAYLOAD_C = mrc_pkg::BYTE_W'(MAX_PAYLOAD);

   logic [15:0]                   crc_ff, crc_in, crc_fed;
   logic [mrc_pkg::BYTE_W-1:0]    delay0_ff, delay1_ff;
   logic [mrc_pkg::LEN_W-1:0]     count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [mrc_pkg::BYTE_W-1:0]    addr_ff, addr_in;
   logic [mrc_pkg::BYTE_W-1:0]    func_ff, func_in;
   logic [mrc_pkg::BYTE_W-1:0]    cnt_ff, cnt_in;
   logic [mrc_pkg::PAY_W-1:0]     payload_ff, payload_in, payload_mask;
   logic                          crc_ok;

   mrc_crc_byte u_crc (
      .crc_cur  (crc_ff),
      .data     (delay1_ff),
      .crc_next (crc_fed)
   );

   always_comb begin
      addr_in    = (count_ff == 9'd0) ? rx_byte : addr_ff;
      func_in    = (count_ff == 9'd1) ? rx_byte : func_ff;
      cnt_in     = (count_ff == 9'd2) ? rx_byte : cnt_ff;
      payload_in = payload_ff;
      for (int i = 0; i < mrc_pkg::PAY_BYTES; i++) begin
         if (i < MAX_PAYLOAD && count_ff == mrc_pkg::LEN_W'(3 + i)) begin
            payload_in[i*mrc_pkg::BYTE_W +: mrc_pkg::BYTE_W] = rx_byte;
         end
      end
      crc_in = (count_ff >= 9'd2) ? crc_fed : crc_ff;
      if (count_ff >= MAX_FRAME_C) begin
         ovf_in   = 1'b1;
         count_in = count_ff;
      end else begin
         ovf_in   = ovf_ff;
         count_in = count_ff + 9'd1;
      end
   end

   // trailing bytes: low crc byte is the older one
   assign crc_ok = (crc_in[7:0] == delay0_ff) && (crc_in[15:8] == rx_byte);

   always_comb begin
      for (int i = 0; i < mrc_pkg::PAY_BYTES; i++) begin
         payload_mask[i*mrc_pkg::BYTE_W +: mrc_pkg::BYTE_W] =
            (mrc_pkg::BYTE_W'(i) < cnt_in) ? 8'hFF : 8'h00;
      end
      result.slave_address      = addr_in;
      result.function_code      = func_in;
      result.count_or_exception = cnt_in;
      result.frame_length       = count_in;
      result.payload_word       = '0;
      if (count_in < mrc_pkg::MIN_FRAME || ovf_in || !crc_ok) begin
         result.status = mrc_pkg::STATUS_INVALID;
      end else if (func_in >= mrc_pkg::EXC_BASE) begin
         result.status = mrc_pkg::STATUS_EXCEPTION;
      end else if ({2'b00, cnt_in} + mrc_pkg::HDR_CRC_BYTES > {1'b0, count_in}) begin
         result.status = mrc_pkg::STATUS_LEN_ERR;
      end else if (cnt_in > MAX_PAYLOAD_C) begin
         result.status = mrc_pkg::STATUS_TOO_LARGE;
      end else begin
         result.status       = mrc_pkg::STATUS_OK;
         result.payload_word = payload_in & payload_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= mrc_pkg::CRC_INIT;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         addr_ff    <= '0;
         func_ff    <= '0;
         cnt_ff     <= '0;
         payload_ff <= '0;
      end else if (go) begin
         if (end_of_frame) begin
            crc_ff     <= mrc_pkg::CRC_INIT;
            count_ff   <= '0;
            ovf_ff     <= 1'b0;
            addr_ff    <= '0;
            func_ff    <= '0;
            cnt_ff     <= '0;
            payload_ff <= '0;
         end else begin
            crc_ff     <= crc_in;
            count_ff   <= count_in;
            ovf_ff     <= ovf_in;
            addr_ff    <= addr_in;
            func_ff    <= func_in;
            cnt_ff     <= cnt_in;
            payload_ff <= payload_in;
         end
      end
   end

   // delay line, no reset needed
   always_ff @(posedge clock) begin
      if (go) begin
         delay1_ff <= delay0_ff;
         delay0_ff <= rx_byte;
      end
   end

endmodule

// ===== hw/rtl/modbus_rtu_response_checker.sv =====
// An accepted req beat passes the input register and then the result register to its rsp beat.
// Throughput: one byte per cycle while no frame end is held by rsp_stall; the byte-wide crc update is the longest path.
// A beat without end_of_frame gives no rsp beat; the last beat of a frame gives one.
// Reset (synchronous, active high) empties both registers and rearms the frame state.
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks Modbus RTU response frames byte by byte and reports a status per frame.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
   parameter int MAX_PAYLOAD = 8,
   parameter int MAX_FRAME   = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mrc_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                           req_end_of_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mrc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mrc_pkg::BYTE_W-1:0]     rsp_slave_address,
   output logic [mrc_pkg::BYTE_W-1:0]     rsp_function_code,
   output logic [mrc_pkg::BYTE_W-1:0]     rsp_count_or_exception,
   output logic [mrc_pkg::PAY_W-1:0]      rsp_payload_word,
   output logic [mrc_pkg::LEN_W-1:0]      rsp_frame_length
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [mrc_pkg::BYTE_W-1:0]    s1_byte_ff;
   logic                          s1_eof_ff;
   logic                          s1_go, req_accept;
   logic                          rsp_valid_ff, rsp_valid_in;
   mrc_pkg::result_type           rsp_ff, frame_result;

   // a beat moves on unless it ends a frame and the result register is held
   assign s1_go       = s1_valid_ff && (!s1_eof_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_go;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = (s1_go && s1_eof_ff) || (rsp_valid_ff && rsp_stall);

   mrc_frame #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .MAX_FRAME   (MAX_FRAME)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .go           (s1_go),
      .rx_byte      (s1_byte_ff),
      .end_of_frame (s1_eof_ff),
      .result       (frame_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_rx_byte;
         s1_eof_ff  <= req_end_of_frame;
      end
      if (s1_go && s1_eof_ff) begin
         rsp_ff <= frame_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_slave_address      = rsp_ff.slave_address;
   assign rsp_function_code      = rsp_ff.function_code;
   assign rsp_count_or_exception = rsp_ff.count_or_exception;
   assign rsp_payload_word       = rsp_ff.payload_word;
   assign rsp_frame_length       = rsp_ff.frame_length;

   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_eof_ff && rsp_valid_ff)
      else $error("req stalled without a held frame end");

   a_ok_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrc_pkg::STATUS_OK |-> rsp_frame_length >= 9'd5)
      else $error("ok status on a frame shorter than header and crc");

   a_payload_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mrc_pkg::STATUS_OK |-> rsp_payload_word == '0)
      else $error("payload reported on a failed frame");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_length <= mrc_pkg::LEN_W'(MAX_FRAME))
      else $error("frame length beyond saturation limit");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_eof_ff |=> rsp_valid)
      else $error("frame end did not produce a result");

endmodule

// ===== dv/tb_modbus_rtu_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_checker
// Feeds response frames byte by byte: a short table of hand-built frames, then
// random frames, mostly well formed with a correct crc, plus broken, short and
// oversized ones. A local model predicts the status beat of frames the table
// gives none for; a scoreboard compares it field by field with the rsp channel.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_checker;

   localparam int DIR_ROWS      = 23;
   localparam int TOTAL_BEATS   = DIR_ROWS + 1900;
   localparam int CALM_AFTER    = TOTAL_BEATS - 200;
   localparam int MAX_FRAME_LEN = 256;

   typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} beat_src_type;

   typedef struct {
      beat_src_type         src;
      logic [7:0]           data;
      bit                   eof;
      bit                   typed;
      mrc_pkg::result_type  want;
   } stim_row_type;

   localparam mrc_pkg::result_type NO_RESULT = '0;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic [mrc_pkg::BYTE_W-1:0]   req_rx_byte      = '0;
   logic                         req_end_of_frame = 1'b0;
   logic                         rsp_stall        = 1'b0;
   logic                         req_stall;
   logic                         rsp_valid;
   logic [mrc_pkg::STATUS_W-1:0] rsp_status;
   logic [mrc_pkg::BYTE_W-1:0]   rsp_slave_address;
   logic [mrc_pkg::BYTE_W-1:0]   rsp_function_code;
   logic [mrc_pkg::BYTE_W-1:0]   rsp_count_or_exception;
   logic [mrc_pkg::PAY_W-1:0]    rsp_payload_word;
   logic [mrc_pkg::LEN_W-1:0]    rsp_frame_length;

   modbus_rtu_response_checker dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_rx_byte            (req_rx_byte),
      .req_end_of_frame       (req_end_of_frame),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_slave_address      (rsp_slave_address),
      .rsp_function_code      (rsp_function_code),
      .rsp_count_or_exception (rsp_count_or_exception),
      .rsp_payload_word       (rsp_payload_word),
      .rsp_frame_length       (rsp_frame_length)
   );

   always #10 clock = ~clock;

   // frame checker model state
   logic [15:0]               crc_run;
   logic [7:0]                dly0, dly1;
   logic [mrc_pkg::LEN_W-1:0] byte_cnt;
   logic [7:0]                cap_addr, cap_func, cap_count;
   logic [mrc_pkg::PAY_W-1:0] cap_pay;
   bit                        overflow;

   mrc_pkg::result_type  pending_status[$];
   logic [7:0]  frame_q[$];
   bit          calm = 1'b0;
   int          beats_sent  = 0;
   int          frames_sent = 0;
   int          rsp_seen    = 0;
   int          errors      = 0;
   int          status_seen[5] = '{0, 0, 0, 0, 0};
   int          stall_left  = 0;

   stim_row_type dir_tab [DIR_ROWS] = '{
      '{SRC_LIT,    8'hFF, 1'b1, 1'b1,
        '{mrc_pkg::STATUS_INVALID, 8'hFF, 8'h00, 8'h00, 64'h0, 9'd1}},
      '{SRC_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h80, 1'b1, 1'b1,
        '{mrc_pkg::STATUS_INVALID, 8'h00, 8'h80, 8'h00, 64'h0, 9'd2}},
      '{SRC_LIT,    8'h11, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h22, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h33, 1'b1, 1'b1,
        '{mrc_pkg::STATUS_INVALID, 8'h11, 8'h22, 8'h33, 64'h0, 9'd3}},
      '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h03, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h02, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'hAB, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'hCD, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h80, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h02, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_HI, 8'h00, 1'b1, 1'b1,
        '{mrc_pkg::STATUS_EXCEPTION, 8'h0A, 8'h80, 8'h02, 64'h0, 9'd5}},
      '{SRC_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h7F, 1'b0, 1'b0, NO_RESULT},
      '{SRC_LIT,    8'h05, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{SRC_CRC_HI, 8'h00, 1'b1, 1'b1,
        '{mrc_pkg::STATUS_LEN_ERR, 8'h01, 8'h7F, 8'h05, 64'h0, 9'd5}}
   };

   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void frame_rearm();
      crc_run   = mrc_pkg::CRC_INIT;
      byte_cnt  = '0;
      cap_addr  = '0;
      cap_func  = '0;
      cap_count = '0;
      cap_pay   = '0;
      overflow  = 1'b0;
   endfunction

   // returns 1 when the beat closes a frame, with the status beat in r
   function automatic bit frame_step(input logic [7:0] b, input bit last,
                                     output mrc_pkg::result_type r);
      int n;
      int len;
      n = int'(byte_cnt);
      r = NO_RESULT;
      if (n == 0)
         cap_addr = b;
      else if (n == 1)
         cap_func = b;
      else if (n == 2)
         cap_count = b;
      else if (n < 3 + mrc_pkg::PAY_BYTES)
         cap_pay[(n - 3) * 8 +: 8] = b;
      if (n >= 2)
         crc_run = crc16_byte(crc_run, dly1);
      dly1 = dly0;
      dly0 = b;
      if (n >= MAX_FRAME_LEN)
         overflow = 1'b1;
      else
         byte_cnt = mrc_pkg::LEN_W'(n + 1);
      if (!last)
         return 1'b0;
      len = int'(byte_cnt);
      r.slave_address      = cap_addr;
      r.function_code      = cap_func;
      r.count_or_exception = cap_count;
      r.frame_length       = byte_cnt;
      if (len < int'(mrc_pkg::MIN_FRAME) || overflow || crc_run[7:0] != dly1 ||
          crc_run[15:8] != dly0) begin
         r.status = mrc_pkg::STATUS_INVALID;
      end else if (cap_func >= mrc_pkg::EXC_BASE) begin
         r.status = mrc_pkg::STATUS_EXCEPTION;
      end else if (int'(cap_count) + int'(mrc_pkg::HDR_CRC_BYTES) > len) begin
         r.status = mrc_pkg::STATUS_LEN_ERR;
      end else if (int'(cap_count) > mrc_pkg::PAY_BYTES) begin
         r.status = mrc_pkg::STATUS_TOO_LARGE;
      end else begin
         r.status       = mrc_pkg::STATUS_OK;
         r.payload_word = cap_pay & ~({mrc_pkg::PAY_W{1'b1}} << (int'(cap_count) * 8));
      end
      frame_rearm();
      return 1'b1;
   endfunction

   function automatic void build_frame(input int hdr_len, input logic [7:0] func,
                                       input logic [7:0] count, input int data_len,
                                       input bit good);
      logic [15:0] c;
      frame_q.delete();
      frame_q.push_back(8'($urandom_range(0, 255)));
      if (hdr_len > 1)
         frame_q.push_back(func);
      if (hdr_len > 2)
         frame_q.push_back(count);
      repeat (data_len)
         frame_q.push_back(8'($urandom_range(0, 255)));
      c = mrc_pkg::CRC_INIT;
      foreach (frame_q[i])
         c = crc16_byte(c, frame_q[i]);
      if (!good)
         c ^= 16'($urandom_range(1, 65535));
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
   endfunction

   task automatic send_beat(input logic [7:0] b, input bit eof, input bit typed,
                            input mrc_pkg::result_type want);
      mrc_pkg::result_type pred;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_rx_byte      <= b;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      beats_sent++;
      if (frame_step(b, eof, pred))
         pending_status.push_back(typed ? want : pred);
      if (eof)
         frames_sent++;
   endtask

   function automatic void field_check(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      mrc_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_status.size() == 0) begin
            $error("rsp beat with no frame outstanding");
            errors++;
         end else begin
            want = pending_status.pop_front();
            rsp_seen++;
            status_seen[want.status]++;
            field_check("status", 64'(want.status), 64'(rsp_status));
            field_check("slave_address", 64'(want.slave_address),
                        64'(rsp_slave_address));
            field_check("function_code", 64'(want.function_code),
                        64'(rsp_function_code));
            field_check("count_or_exception", 64'(want.count_or_exception),
                        64'(rsp_count_or_exception));
            field_check("payload_word", want.payload_word, rsp_payload_word);
            field_check("frame_length", 64'(want.frame_length),
                        64'(rsp_frame_length));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [15:0] tx_crc;
      logic [7:0]  b;
      logic [7:0]  func;
      logic [7:0]  count;
      int          kind;
      int          frame_no;
      bit          good;
      frame_rearm();
      dly0 = '0;
      dly1 = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      tx_crc = mrc_pkg::CRC_INIT;
      foreach (dir_tab[i]) begin
         case (dir_tab[i].src)
            SRC_LIT:    b = dir_tab[i].data;
            SRC_CRC_LO: b = tx_crc[7:0];
            default:    b = tx_crc[15:8];
         endcase
         send_beat(b, dir_tab[i].eof, dir_tab[i].typed, dir_tab[i].want);
         if (dir_tab[i].eof)
            tx_crc = mrc_pkg::CRC_INIT;
         else if (dir_tab[i].src == SRC_LIT)
            tx_crc = crc16_byte(tx_crc, b);
      end

      frame_no = 0;
      while (beats_sent < TOTAL_BEATS) begin
         frame_no++;
         if (frame_no == 90) begin
            req_valid <= 1'b0;
            while (pending_status.size() != 0) @(posedge clock);
         end
         func  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(128, 255))
                                               : 8'($urandom_range(0, 127));
         good  = $urandom_range(0, 6) != 0;
         count = 8'($urandom_range(0, mrc_pkg::PAY_BYTES));
         kind  = $urandom_range(0, 99);
         if (frame_no == 30) begin
            // exactly at the length limit
            build_frame(3, 8'h03, 8'h08, MAX_FRAME_LEN - 5, 1'b1);
         end else if (frame_no == 60) begin
            // past the limit, counter saturates
            build_frame(3, 8'h10, 8'hFF, MAX_FRAME_LEN - 5 + $urandom_range(1, 8), 1'b1);
         end else if (kind < 8) begin
            frame_q.delete();
            repeat ($urandom_range(1, 3))
               frame_q.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 13) begin
            build_frame(2, func, 8'h00, 0, good);
         end else if (kind < 55) begin
            build_frame(3, func, count, count, good);
         end else if (kind < 65) begin
            count = 8'($urandom_range(mrc_pkg::PAY_BYTES + 1, 20));
            build_frame(3, func, count, count, good);
         end else if (kind < 78) begin
            build_frame(3, func, count, count + $urandom_range(1, 3), good);
         end else begin
            build_frame(3, func, 8'($urandom_range(0, 255)), $urandom_range(0, 10), good);
         end
         foreach (frame_q[i])
            send_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_RESULT);
         if (beats_sent >= CALM_AFTER)
            calm = 1'b1;
      end
      req_valid <= 1'b0;

      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d req beats in %0d frames, %0d rsp beats compared",
               beats_sent, frames_sent, rsp_seen);
      $display("status mix: ok %0d, invalid %0d, exception %0d, length %0d, too large %0d",
               status_seen[mrc_pkg::STATUS_OK], status_seen[mrc_pkg::STATUS_INVALID],
               status_seen[mrc_pkg::STATUS_EXCEPTION], status_seen[mrc_pkg::STATUS_LEN_ERR],
               status_seen[mrc_pkg::STATUS_TOO_LARGE]);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
